// File: hw/rtl/cpd_pkg.sv
// cpd_pkg: shared types and constants of the command packet deframer.
// Used by cpd_ctrl, cpd_datapath, command_packet_deframer and cpd_checker.
// No dependencies.
`default_nettype none

package cpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 5;
    localparam int CODE_W    = 2;
    localparam int CFG_IDX_W = 8;
    localparam int TDATA_W   = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 8'd1;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hA5;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 5'd20;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;

    typedef enum logic [CODE_W-1:0] {
        ERR_START    = 2'd0,
        ERR_LENGTH   = 2'd1,
        ERR_CHECKSUM = 2'd2
    } t_err_code;

    typedef enum logic [2:0] {
        ST_WAIT_START,
        ST_LENGTH,
        ST_PAYLOAD,
        ST_CHECKSUM,
        ST_HUNT,
        ST_READ,
        ST_PUSH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic      take;      // rx byte accepted, fold into checksum
        logic      xor_clr;
        logic      pos_clr;
        logic      len_load;
        logic      store;
        logic      rd;
        logic      pos_inc;
        logic      push_pay;
        logic      push_err;
        t_err_code err_code;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_start;
        logic len_bad;
        logic pos_done;
        logic xor_zero;
        logic emit_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: hw/rtl/cpd_ctrl.sv
// cpd_ctrl: framing state machine of the command packet deframer.
// Drives datapath commands from datapath status; depends on cpd_pkg.
`default_nettype none

module cpd_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_s_tvalid,
    output logic            o_s_tready,
    input  cpd_pkg::t_dp_sts i_sts,
    output cpd_pkg::t_dp_cmd o_cmd
);
    import cpd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_rx_state;
    logic   w_take;

    assign w_rx_state = (r_state == ST_WAIT_START) || (r_state == ST_LENGTH) ||
                        (r_state == ST_PAYLOAD) || (r_state == ST_CHECKSUM) ||
                        (r_state == ST_HUNT);
    assign o_s_tready = w_rx_state && i_sts.out_free;
    assign w_take     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT_START;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_WAIT_START: begin
                if (w_take) n_state = i_sts.is_start ? ST_LENGTH : ST_HUNT;
            end
            ST_LENGTH: begin
                if (w_take) n_state = i_sts.len_bad ? ST_HUNT : ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                if (w_take && i_sts.pos_done) n_state = ST_CHECKSUM;
            end
            ST_CHECKSUM: begin
                if (w_take) n_state = i_sts.xor_zero ? ST_READ : ST_HUNT;
            end
            ST_HUNT: begin
                if (w_take && i_sts.is_start) n_state = ST_LENGTH;
            end
            ST_READ: begin
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (i_sts.out_free) n_state = i_sts.emit_last ? ST_WAIT_START : ST_READ;
            end
            default: n_state = ST_HUNT;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.take = w_take;
        unique case (r_state)
            ST_WAIT_START: begin
                if (w_take && !i_sts.is_start) begin
                    o_cmd.push_err = 1'b1;
                    o_cmd.err_code = ERR_START;
                    o_cmd.xor_clr  = 1'b1;
                    o_cmd.pos_clr  = 1'b1;
                end
            end
            ST_LENGTH: begin
                if (w_take) begin
                    if (i_sts.len_bad) begin
                        o_cmd.push_err = 1'b1;
                        o_cmd.err_code = ERR_LENGTH;
                        o_cmd.xor_clr  = 1'b1;
                        o_cmd.pos_clr  = 1'b1;
                    end else begin
                        o_cmd.len_load = 1'b1;
                    end
                end
            end
            ST_PAYLOAD: begin
                o_cmd.store = w_take;
            end
            ST_CHECKSUM: begin
                if (w_take) begin
                    o_cmd.xor_clr = 1'b1;
                    o_cmd.pos_clr = 1'b1;
                    if (!i_sts.xor_zero) begin
                        o_cmd.push_err = 1'b1;
                        o_cmd.err_code = ERR_CHECKSUM;
                    end
                end
            end
            ST_HUNT: begin
                if (w_take && !i_sts.is_start) begin
                    o_cmd.xor_clr = 1'b1;
                    o_cmd.pos_clr = 1'b1;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
            end
            ST_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push_pay = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.xor_clr = 1'b1;
                        o_cmd.pos_clr = 1'b1;
                    end else begin
                        o_cmd.pos_inc = 1'b1;
                    end
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/cpd_datapath.sv
// cpd_datapath: config registers, checksum, counters, payload buffer and
// output register of the command packet deframer. Depends on cpd_pkg.
`default_nettype none

module cpd_datapath #(
    parameter int MAX_PAYLOAD = 20
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [cpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [cpd_pkg::BYTE_W-1:0]     i_cfg_data,
    input  wire  [cpd_pkg::BYTE_W-1:0]     i_byte,
    input  cpd_pkg::t_dp_cmd               i_cmd,
    output cpd_pkg::t_dp_sts               o_sts,
    input  wire                            i_out_ack,
    output logic                           o_out_valid,
    output logic                           o_kind,
    output logic [cpd_pkg::CODE_W-1:0]     o_error_code,
    output logic [cpd_pkg::BYTE_W-1:0]     o_error_value,
    output logic [cpd_pkg::BYTE_W-1:0]     o_payload_byte,
    output logic [cpd_pkg::LEN_W-1:0]      o_byte_index,
    output logic [cpd_pkg::LEN_W-1:0]      o_packet_length,
    output logic                           o_last
);
    import cpd_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_B = BYTE_W'(MAX_PAYLOAD);

    logic [BYTE_W-1:0] r_start_byte;
    logic [LEN_W-1:0]  r_max_length;
    logic [BYTE_W-1:0] r_xor;
    logic [BYTE_W-1:0] n_xor;
    logic [LEN_W-1:0]  r_byte_pos;
    logic [LEN_W-1:0]  n_byte_pos;
    logic [LEN_W-1:0]  r_length;
    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] r_rd_data;
    logic [AW-1:0]     w_addr;
    logic [LEN_W-1:0]  w_pos_next;
    logic [BYTE_W-1:0] w_limit;
    logic [BYTE_W-1:0] w_residue;
    logic [BYTE_W-1:0] w_err_value;

    assign w_addr     = AW'(r_byte_pos);
    assign w_pos_next = LEN_W'(r_byte_pos + 1'b1);
    assign w_residue  = r_xor ^ i_byte;
    assign w_limit    = (BYTE_W'(r_max_length) < MAX_PAYLOAD_B) ?
                        BYTE_W'(r_max_length) : MAX_PAYLOAD_B;

    assign o_sts.is_start  = (i_byte == r_start_byte);
    assign o_sts.len_bad   = (i_byte == '0) || (i_byte > w_limit);
    assign o_sts.pos_done  = (w_pos_next >= r_length);
    assign o_sts.xor_zero  = (w_residue == '0);
    assign o_sts.emit_last = (w_pos_next == r_length);
    assign o_sts.out_free  = !o_out_valid || i_out_ack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_START_BYTE) r_start_byte <= i_cfg_data;
            if (i_cfg_index == REG_MAX_LENGTH) r_max_length <= i_cfg_data[LEN_W-1:0];
        end
    end

    always_comb begin
        n_xor = r_xor;
        if (i_cmd.xor_clr) n_xor = '0;
        else if (i_cmd.take) n_xor = w_residue;

        n_byte_pos = r_byte_pos;
        if (i_cmd.pos_clr || i_cmd.len_load) n_byte_pos = '0;
        else if (i_cmd.store || i_cmd.pos_inc) n_byte_pos = w_pos_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor      <= '0;
            r_byte_pos <= '0;
            r_length   <= '0;
        end else begin
            r_xor      <= n_xor;
            r_byte_pos <= n_byte_pos;
            if (i_cmd.len_load) r_length <= i_byte[LEN_W-1:0];
        end
    end

    // payload buffer, one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) r_mem[w_addr] <= i_byte;
        if (i_cmd.rd) r_rd_data <= r_mem[w_addr];
    end

    always_comb begin
        case (i_cmd.err_code)
            ERR_CHECKSUM: w_err_value = w_residue;
            default:      w_err_value = i_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.push_pay || i_cmd.push_err) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ack) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_err) begin
            o_kind          <= KIND_ERROR;
            o_error_code    <= i_cmd.err_code;
            o_error_value   <= w_err_value;
            o_payload_byte  <= '0;
            o_byte_index    <= '0;
            o_packet_length <= '0;
            o_last          <= 1'b1;
        end else if (i_cmd.push_pay) begin
            o_kind          <= KIND_PAYLOAD;
            o_error_code    <= '0;
            o_error_value   <= '0;
            o_payload_byte  <= r_rd_data;
            o_byte_index    <= r_byte_pos;
            o_packet_length <= r_length;
            o_last          <= o_sts.emit_last;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/command_packet_deframer.sv
// command_packet_deframer: top level, controller plus datapath.
// Depends on cpd_pkg, cpd_ctrl and cpd_datapath.
//
// Usage:
//   Slave stream (i_s_*) carries received serial bytes, one per request.
//   Packets are: start byte, length N, N payload bytes (first is the
//   command), XOR checksum byte; XOR over the whole packet must be zero.
//   Master stream (o_m_*) carries results: tuser=0 payload byte of a good
//   packet (tlast on the N-th), tuser=1 error report (always tlast).
//   Config channel (i_cfg_*) writes start_byte (index 0) and max_length
//   (index 1); it is always ready and should be written while idle.
// Timing:
//   While framing, one byte is taken per cycle as long as the output
//   register is empty or being read. An error result is in the output
//   register the cycle after its byte. After a good checksum the
//   N payload results follow, each by a buffer read and then an output
//   load, held by any stall; no bytes are taken during the run. After
//   an error, non-start bytes are dropped silently. Reset restores start
//   byte 0xA5 and limit 20, empties the output and waits for a start byte.
//   When the receiver stalls the output register holds its result and no
//   byte is taken until that result is read.
`default_nettype none

module command_packet_deframer #(
    parameter int MAX_PAYLOAD = 20
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // config write channel
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [cpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [cpd_pkg::BYTE_W-1:0]     i_cfg_data,
    // byte input stream
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    input  wire  [cpd_pkg::BYTE_W-1:0]     i_s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    // [1:0] error_code, [9:2] error_value, [17:10] payload_byte,
    // [22:18] byte_index, [27:23] packet_length, [31:28] zero
    output logic [cpd_pkg::TDATA_W-1:0]    o_m_tdata,
    output logic                           o_m_tuser,   // [0] kind
    output logic                           o_m_tlast    // last
);
    import cpd_pkg::*;

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [CODE_W-1:0] w_error_code;
    logic [BYTE_W-1:0] w_error_value;
    logic [BYTE_W-1:0] w_payload_byte;
    logic [LEN_W-1:0]  w_byte_index;
    logic [LEN_W-1:0]  w_packet_length;

    assign o_cfg_ready = 1'b1;

    cpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cpd_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_byte          (i_s_tdata),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_out_ack       (i_m_tready),
        .o_out_valid     (o_m_tvalid),
        .o_kind          (o_m_tuser),
        .o_error_code    (w_error_code),
        .o_error_value   (w_error_value),
        .o_payload_byte  (w_payload_byte),
        .o_byte_index    (w_byte_index),
        .o_packet_length (w_packet_length),
        .o_last          (o_m_tlast)
    );

    assign o_m_tdata = {4'b0000, w_packet_length, w_byte_index, w_payload_byte,
                        w_error_value, w_error_code};

endmodule

`default_nettype wire

// File: hw/rtl/cpd_checker.sv
// cpd_assert: port-level checks on the deframer result stream, bound to
// command_packet_deframer. Depends on cpd_pkg.
`default_nettype none

module cpd_assert (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            o_m_tvalid,
    input wire                            i_m_tready,
    input wire [cpd_pkg::TDATA_W-1:0]     o_m_tdata,
    input wire                            o_m_tuser,
    input wire                            o_m_tlast
);
    import cpd_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // error reports are single-result runs with empty payload fields
    a_err_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_ERROR) |->
        o_m_tlast && (o_m_tdata[27:10] == '0) &&
        (o_m_tdata[1:0] <= ERR_CHECKSUM))
        else $error("malformed error report");

    // tlast marks exactly the final payload byte of a run
    a_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_PAYLOAD) |->
        (o_m_tdata[22:18] < o_m_tdata[27:23]) &&
        (o_m_tlast == ((o_m_tdata[22:18] + 5'd1) == o_m_tdata[27:23])))
        else $error("bad payload index or tlast");

    // payload runs count up without gaps
    a_run_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && (o_m_tuser == KIND_PAYLOAD) && !o_m_tlast
        ##1 o_m_tvalid |->
        (o_m_tuser == KIND_PAYLOAD) &&
        (o_m_tdata[22:18] == ($past(o_m_tdata[22:18]) + 5'd1)) &&
        (o_m_tdata[27:23] == $past(o_m_tdata[27:23])))
        else $error("payload run out of sequence");

    // output empty after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind command_packet_deframer cpd_assert u_cpd_assert (.*);

`default_nettype wire
